// ----- rtl/core/dtq_pkg.sv -----
// Shared types and constants for the delta timer queue.
// Used by dtq_cell, dtq_ctrl and delta_timer_queue; depends on nothing.
`default_nettype none

package dtq_pkg;

  localparam int DELAY_W    = 32;
  localparam int OUT_SLOT_W = 4;
  localparam int OPC_W      = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  // Search token that walks the list from the head, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic [DELAY_W-1:0] rem;
  } walk_tok_t;

  // Displaced entry that an insert pushes toward the tail.
  typedef struct packed {
    logic               valid;
    logic [DELAY_W-1:0] delta;
  } carry_tok_t;

  // Gap left by a delete; it pulls the rest of the list toward the head.
  typedef struct packed {
    logic               valid;
    logic [DELAY_W-1:0] add;
  } hole_tok_t;

endpackage

`default_nettype wire

// ----- rtl/core/delta_timer_queue.sv -----
// Top level of the delta timer queue: a chain of list cells and the sequencer.
// Depends on dtq_pkg, dtq_cell and dtq_ctrl.
`default_nettype none

// A command beat is taken when start is high and busy is low. Each command
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot hold it off, and the next command may be taken in that same cycle.
// The entries sit in a row of cells in delta order, head at cell 0. Insert
// and delete send a token along the row one cell per cycle: the search token
// finds the place, then a displaced entry (insert) or a gap (delete) moves
// on toward the tail. An insert or delete is done once the displaced entry or
// the gap passes the last entry; a read, or a command that fails (full pool,
// unused slot), launches no token and goes straight to the finishing state.
// After reset the block is ready at once.
module delta_timer_queue #(
  parameter int ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [dtq_pkg::OPC_W-1:0]        opcode,
  input  wire logic [dtq_pkg::DELAY_W-1:0]      delay,
  input  wire logic [3:0]                       slot,
  output logic                                  done,
  output logic [dtq_pkg::OUT_SLOT_W-1:0]        assigned_slot,
  output logic                                  error,
  output logic                                  head_valid,
  output logic [dtq_pkg::OUT_SLOT_W-1:0]        head_slot,
  output logic [dtq_pkg::DELAY_W-1:0]           head_delay
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  dtq_pkg::walk_tok_t            launch;
  logic                          is_insert;
  logic [SW-1:0]                 new_slot;
  logic [SW-1:0]                 target;
  logic [CW-1:0]                 count;
  logic                          any_done;

  dtq_pkg::walk_tok_t            walk_o   [ENTRIES];
  dtq_pkg::carry_tok_t           carry_o  [ENTRIES];
  logic [SW-1:0]                 cslot_o  [ENTRIES];
  dtq_pkg::hole_tok_t            hole_o   [ENTRIES];
  logic [SW-1:0]                 cell_slot [ENTRIES];
  logic [dtq_pkg::DELAY_W-1:0]   cell_delta[ENTRIES];
  logic [ENTRIES-1:0]            cell_valid;
  logic [ENTRIES-1:0]            cell_active;
  logic [ENTRIES-1:0]            cell_done;

  assign any_done = |cell_done;

  dtq_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .opcode         (opcode),
    .delay          (delay),
    .slot           (slot),
    .any_done       (any_done),
    .head_slot_cell (cell_slot[0]),
    .head_delta_cell(cell_delta[0]),
    .busy           (busy),
    .launch         (launch),
    .is_insert      (is_insert),
    .new_slot       (new_slot),
    .target         (target),
    .count          (count),
    .done           (done),
    .assigned_slot  (assigned_slot),
    .error          (error),
    .head_valid     (head_valid),
    .head_slot      (head_slot),
    .head_delay     (head_delay)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dtq_pkg::walk_tok_t          w_in;
    dtq_pkg::carry_tok_t         c_in;
    logic [SW-1:0]               cs_in;
    dtq_pkg::hole_tok_t          h_in;
    logic                        r_valid;
    logic [SW-1:0]               r_slot;
    logic [dtq_pkg::DELAY_W-1:0] r_delta;

    assign cell_valid[i] = CW'(i) < count;

    if (i == 0) begin : g_head
      assign w_in  = launch;
      assign c_in  = '0;
      assign cs_in = '0;
      assign h_in  = '0;
    end else begin : g_link
      assign w_in  = walk_o[i-1];
      assign c_in  = carry_o[i-1];
      assign cs_in = cslot_o[i-1];
      assign h_in  = hole_o[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_slot  = '0;
      assign r_delta = '0;
    end else begin : g_right
      assign r_valid = cell_valid[i+1];
      assign r_slot  = cell_slot[i+1];
      assign r_delta = cell_delta[i+1];
    end

    dtq_cell #(
      .SW(SW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .is_insert     (is_insert),
      .valid_here    (cell_valid[i]),
      .new_slot      (new_slot),
      .target        (target),
      .walk_in       (w_in),
      .carry_in      (c_in),
      .carry_slot_in (cs_in),
      .hole_in       (h_in),
      .right_valid   (r_valid),
      .right_slot    (r_slot),
      .right_delta   (r_delta),
      .walk_out      (walk_o[i]),
      .carry_out     (carry_o[i]),
      .carry_slot_out(cslot_o[i]),
      .hole_out      (hole_o[i]),
      .slot_q        (cell_slot[i]),
      .delta_q       (cell_delta[i]),
      .active        (cell_active[i]),
      .done          (cell_done[i])
    );
  end

  // Only one token may be in flight along the row.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(cell_active))
    else $error("more than one token in the cell row");

  // An idle sequencer leaves no token behind in the row.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cell_active == '0))
    else $error("token active while the block is idle");

  // A failed command never reports an assigned slot.
  a_err_slot: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (assigned_slot == '0))
    else $error("slot reported on a failed command");

  // The entry count never passes the pool size.
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(ENTRIES))
    else $error("entry count beyond pool size");

endmodule

`default_nettype wire

// ----- rtl/core/dtq_cell.sv -----
// One list position of the delta timer queue: the slot and delta stored there,
// plus the token registers that move between neighbors. Depends on dtq_pkg.
`default_nettype none

module dtq_cell #(
  parameter int SW = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         is_insert,
  input  wire logic                         valid_here,
  input  wire logic [SW-1:0]                new_slot,
  input  wire logic [SW-1:0]                target,
  input  wire dtq_pkg::walk_tok_t           walk_in,
  input  wire dtq_pkg::carry_tok_t          carry_in,
  input  wire logic [SW-1:0]                carry_slot_in,
  input  wire dtq_pkg::hole_tok_t           hole_in,
  input  wire logic                         right_valid,
  input  wire logic [SW-1:0]                right_slot,
  input  wire logic [dtq_pkg::DELAY_W-1:0]  right_delta,
  output dtq_pkg::walk_tok_t                walk_out,
  output dtq_pkg::carry_tok_t               carry_out,
  output logic [SW-1:0]                     carry_slot_out,
  output dtq_pkg::hole_tok_t                hole_out,
  output logic [SW-1:0]                     slot_q,
  output logic [dtq_pkg::DELAY_W-1:0]       delta_q,
  output logic                              active,
  output logic                              done
);

  dtq_pkg::walk_tok_t             walk_here;
  dtq_pkg::carry_tok_t            carry_here;
  logic [SW-1:0]                  carry_slot_here;
  dtq_pkg::hole_tok_t             hole_here;
  logic [SW-1:0]                  slot_next;
  logic [dtq_pkg::DELAY_W-1:0]    delta_next;
  logic                           pull;
  logic [dtq_pkg::DELAY_W-1:0]    pull_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_here.valid  <= 1'b0;
      carry_here.valid <= 1'b0;
      hole_here.valid  <= 1'b0;
    end else begin
      walk_here.valid  <= walk_in.valid;
      carry_here.valid <= carry_in.valid;
      hole_here.valid  <= hole_in.valid;
    end
    walk_here.rem    <= walk_in.rem;
    carry_here.delta <= carry_in.delta;
    carry_slot_here  <= carry_slot_in;
    hole_here.add    <= hole_in.add;
    slot_q           <= slot_next;
    delta_q          <= delta_next;
  end

  always_comb begin
    walk_out       = '0;
    carry_out      = '0;
    carry_slot_out = slot_q;
    hole_out       = '0;
    done           = 1'b0;
    slot_next      = slot_q;
    delta_next     = delta_q;
    pull           = 1'b0;
    pull_add       = '0;

    if (walk_here.valid) begin
      if (is_insert) begin
        // Stop at the end of the list or at the first delta that is not smaller.
        if (!valid_here || walk_here.rem <= delta_q) begin
          slot_next  = new_slot;
          delta_next = walk_here.rem;
          if (valid_here) begin
            carry_out.valid = 1'b1;
            carry_out.delta = delta_q - walk_here.rem;
          end else begin
            done = 1'b1;
          end
        end else begin
          walk_out.valid = 1'b1;
          walk_out.rem   = walk_here.rem - delta_q;
        end
      end else if (slot_q == target) begin
        pull     = 1'b1;
        pull_add = delta_q;
      end else begin
        walk_out = walk_here;
      end
    end

    if (carry_here.valid) begin
      slot_next  = carry_slot_here;
      delta_next = carry_here.delta;
      if (valid_here) begin
        carry_out.valid = 1'b1;
        carry_out.delta = delta_q;
      end else begin
        done = 1'b1;
      end
    end

    if (hole_here.valid) begin
      pull     = 1'b1;
      pull_add = hole_here.add;
    end

    // The successor moves up one place; only the first one gets the freed delta.
    if (pull) begin
      if (right_valid) begin
        slot_next      = right_slot;
        delta_next     = right_delta + pull_add;
        hole_out.valid = 1'b1;
      end else begin
        done = 1'b1;
      end
    end
  end

  assign active = walk_here.valid | carry_here.valid | hole_here.valid;

endmodule

`default_nettype wire

// ----- rtl/core/dtq_ctrl.sv -----
// Command sequencer of the delta timer queue: slot bitmap, entry count,
// token launch and the result registers. Depends on dtq_pkg.
`default_nettype none

module dtq_ctrl #(
  parameter int ENTRIES = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  input  wire logic [dtq_pkg::OPC_W-1:0]               opcode,
  input  wire logic [dtq_pkg::DELAY_W-1:0]             delay,
  input  wire logic [3:0]                              slot,
  input  wire logic                                    any_done,
  input  wire logic [$clog2(ENTRIES)-1:0]              head_slot_cell,
  input  wire logic [dtq_pkg::DELAY_W-1:0]             head_delta_cell,
  output logic                                         busy,
  output dtq_pkg::walk_tok_t                           launch,
  output logic                                         is_insert,
  output logic [$clog2(ENTRIES)-1:0]                   new_slot,
  output logic [$clog2(ENTRIES)-1:0]                   target,
  output logic [$clog2(ENTRIES+1)-1:0]                 count,
  output logic                                         done,
  output logic [dtq_pkg::OUT_SLOT_W-1:0]               assigned_slot,
  output logic                                         error,
  output logic                                         head_valid,
  output logic [dtq_pkg::OUT_SLOT_W-1:0]               head_slot,
  output logic [dtq_pkg::DELAY_W-1:0]                  head_delay
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [ENTRIES-1:0] used;
  logic               err;
  logic               accept;
  logic [SW-1:0]      free_idx;
  logic [6:0]         slot_ext;
  logic [SW-1:0]      del_idx;
  logic               in_range;
  logic               full;
  dtq_pkg::opcode_t   opc;

  assign accept   = start && (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign opc      = dtq_pkg::opcode_t'(opcode);
  assign slot_ext = 7'(slot);
  assign del_idx  = slot_ext[SW-1:0];
  assign in_range = slot_ext < 7'(ENTRIES);
  assign full     = (count == CW'(ENTRIES));

  // Lowest free slot; only looked at when the pool is not full.
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    launch.valid = 1'b0;
    launch.rem   = delay;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_FINISH;
          case (opc)
            dtq_pkg::OP_INSERT: begin
              if (!full) begin
                launch.valid = 1'b1;
                state_next   = ST_RUN;
              end
            end
            dtq_pkg::OP_DELETE: begin
              if (in_range && used[del_idx]) begin
                launch.valid = 1'b1;
                state_next   = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (any_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH);
      if (state == ST_RUN && any_done) begin
        if (is_insert) begin
          count          <= count + CW'(1);
          used[new_slot] <= 1'b1;
        end else begin
          count        <= count - CW'(1);
          used[target] <= 1'b0;
        end
      end
    end

    if (accept) begin
      is_insert <= (opc == dtq_pkg::OP_INSERT);
      new_slot  <= free_idx;
      target    <= del_idx;
      case (opc)
        dtq_pkg::OP_INSERT: err <= full;
        dtq_pkg::OP_DELETE: err <= !(in_range && used[del_idx]);
        default:            err <= 1'b0;
      endcase
    end

    if (state == ST_FINISH) begin
      assigned_slot <= (is_insert && !err) ? dtq_pkg::OUT_SLOT_W'(new_slot) : '0;
      error         <= err;
      head_valid    <= (count != '0);
      head_slot     <= (count != '0) ? dtq_pkg::OUT_SLOT_W'(head_slot_cell) : '0;
      head_delay    <= (count != '0) ? head_delta_cell : '0;
    end
  end

endmodule

`default_nettype wire
